// ===== rtl/xcrfp_pkg.sv =====
// Package for the XOR-checked reply frame parser.
// Holds the parse phases, result kinds, register indexes, reset values and
// the result record. It depends on nothing else.
`default_nettype none

package xcrfp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0]  ACK_CODE_RST          = 8'd6;
  localparam logic [7:0]  NAK_CODE_RST          = 8'd21;
  localparam logic [7:0]  BYTE_PAYLOAD_CODE_RST = 8'd13;
  localparam logic [7:0]  PAIR_PAYLOAD_CODE_RST = 8'd14;
  localparam logic [15:0] GAP_LIMIT_RST         = 16'd5;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_OBJECT  = 3'd1,
    PH_INDEX   = 3'd2,
    PH_MSB     = 3'd3,
    PH_LSB     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_ACK      = 3'd0,
    KIND_NAK      = 3'd1,
    KIND_REPORT   = 3'd2,
    KIND_ELEMENT  = 3'd3,
    KIND_FRAME_OK = 3'd4,
    KIND_CSUM_ERR = 3'd5,
    KIND_TIMEOUT  = 3'd6
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACK_CODE          = 3'd0,
    REG_NAK_CODE          = 3'd1,
    REG_BYTE_PAYLOAD_CODE = 3'd2,
    REG_PAIR_PAYLOAD_CODE = 3'd3,
    REG_GAP_LIMIT         = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] checksum_errors_seen;
    logic [31:0] timeouts_seen;
    logic [7:0]  element_number;
    logic [15:0] value;
    logic [7:0]  index_or_length;
    logic [7:0]  object_id;
    logic [7:0]  command;
    kind_t       kind;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/xor_checked_reply_frame_parser.sv =====
// Top level of the XOR-checked reply frame parser.
// Uses xcrfp_pkg for phases, result kinds, register indexes and the result record.
`default_nettype none

// The parser takes one request per clock: a received byte (tuser 0) or a
// time tick (tuser 1). Each request updates the frame state in the cycle it
// is accepted, and any result it causes is registered before it is offered
// on the master side. A two-entry output buffer (the output register and a skid
// register) lets the slave side keep taking requests while one result waits,
// so the sustained rate is one request per cycle as long as results are
// drained; s_axis_tready drops only when both buffer entries are full.
// Configuration writes are always ready and take effect on the next cycle;
// they should be issued only while no result is outstanding.
module xor_checked_reply_frame_parser
  import xcrfp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // rx_byte[7:0]
  input  wire logic                   s_axis_tuser,   // func[0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // command[7:0], object_id[15:8], index_or_length[23:16], value[39:24],
  // element_number[47:40], timeouts_seen[79:48], checksum_errors_seen[111:80]
  output logic [111:0]                m_axis_tdata,
  output logic [2:0]                  m_axis_tuser,   // kind[2:0]
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0]  ack_code, nak_code, byte_payload_code, pair_payload_code;
  logic [15:0] gap_limit;

  phase_t      phase, phase_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [7:0]  frame_object, frame_object_next;
  logic [7:0]  frame_index, frame_index_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [7:0]  running_checksum, running_checksum_next;
  logic [8:0]  payload_bytes_taken, payload_bytes_taken_next;
  logic [8:0]  payload_total, payload_total_next;
  logic        pair_mode, pair_mode_next;
  logic [15:0] gap_ticks, gap_ticks_next;
  logic [31:0] timeout_count, timeout_count_next;
  logic [31:0] checksum_error_count, checksum_error_count_next;

  logic        accept;
  logic        res_valid;
  result_t     res;
  logic [15:0] gap_inc;
  logic [15:0] gap_lim;
  logic        is_payload_cmd;
  logic [8:0]  taken_inc;

  logic        out_valid;
  result_t     out_data;
  logic        skid_valid;
  result_t     skid_data;
  logic        pop;
  logic        push;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ~skid_valid;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_code          <= ACK_CODE_RST;
      nak_code          <= NAK_CODE_RST;
      byte_payload_code <= BYTE_PAYLOAD_CODE_RST;
      pair_payload_code <= PAIR_PAYLOAD_CODE_RST;
      gap_limit         <= GAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACK_CODE:          ack_code          <= cfg_data[7:0];
        REG_NAK_CODE:          nak_code          <= cfg_data[7:0];
        REG_BYTE_PAYLOAD_CODE: byte_payload_code <= cfg_data[7:0];
        REG_PAIR_PAYLOAD_CODE: pair_payload_code <= cfg_data[7:0];
        REG_GAP_LIMIT:         gap_limit         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_payload_cmd = (frame_command == byte_payload_code) ||
                          (frame_command == pair_payload_code);
  assign gap_inc   = gap_ticks + 16'd1;
  assign gap_lim   = (gap_limit == 16'd0) ? 16'd1 : gap_limit;
  assign taken_inc = payload_bytes_taken + 9'd1;

  always_comb begin
    phase_next                = phase;
    frame_command_next        = frame_command;
    frame_object_next         = frame_object;
    frame_index_next          = frame_index;
    high_byte_hold_next       = high_byte_hold;
    low_byte_hold_next        = low_byte_hold;
    running_checksum_next     = running_checksum;
    payload_bytes_taken_next  = payload_bytes_taken;
    payload_total_next        = payload_total;
    pair_mode_next            = pair_mode;
    gap_ticks_next            = gap_ticks;
    timeout_count_next        = timeout_count;
    checksum_error_count_next = checksum_error_count;
    res_valid                 = 1'b0;
    res.kind                  = KIND_ACK;
    res.command               = frame_command;
    res.object_id             = frame_object;
    res.index_or_length       = frame_index;
    res.value                 = 16'd0;
    res.element_number        = 8'd0;

    if (accept) begin
      if (s_axis_tuser) begin
        // A tick only counts while a frame is open.
        if (phase != PH_IDLE) begin
          if (gap_inc < gap_lim) begin
            gap_ticks_next = gap_inc;
          end else begin
            gap_ticks_next = 16'd0;
            res_valid      = 1'b1;
            phase_next     = PH_IDLE;
            if (phase == PH_CHECK) begin
              checksum_error_count_next = checksum_error_count + 32'd1;
              res.kind = KIND_CSUM_ERR;
            end else begin
              timeout_count_next = timeout_count + 32'd1;
              res.kind = KIND_TIMEOUT;
            end
          end
        end
      end else begin
        gap_ticks_next = 16'd0;
        unique case (phase)
          PH_IDLE: begin
            if (s_axis_tdata == ack_code || s_axis_tdata == nak_code) begin
              res_valid           = 1'b1;
              res.kind            = (s_axis_tdata == ack_code) ? KIND_ACK : KIND_NAK;
              res.command         = s_axis_tdata;
              res.object_id       = 8'd0;
              res.index_or_length = 8'd0;
            end else begin
              frame_command_next       = s_axis_tdata;
              frame_object_next        = 8'd0;
              frame_index_next         = 8'd0;
              high_byte_hold_next      = 8'd0;
              low_byte_hold_next       = 8'd0;
              payload_bytes_taken_next = 9'd0;
              payload_total_next       = 9'd0;
              pair_mode_next           = 1'b0;
              running_checksum_next    = s_axis_tdata;
              phase_next               = PH_OBJECT;
            end
          end
          PH_OBJECT: begin
            frame_object_next     = s_axis_tdata;
            running_checksum_next = running_checksum ^ s_axis_tdata;
            phase_next            = PH_INDEX;
          end
          PH_INDEX: begin
            frame_index_next      = s_axis_tdata;
            running_checksum_next = running_checksum ^ s_axis_tdata;
            if (is_payload_cmd) begin
              // The single byte form wins when both codes match.
              pair_mode_next           = (frame_command != byte_payload_code);
              payload_total_next       = (frame_command != byte_payload_code) ?
                                         {s_axis_tdata, 1'b0} : {1'b0, s_axis_tdata};
              payload_bytes_taken_next = 9'd0;
              phase_next = (s_axis_tdata == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end else begin
              phase_next = PH_MSB;
            end
          end
          PH_MSB: begin
            high_byte_hold_next   = s_axis_tdata;
            running_checksum_next = running_checksum ^ s_axis_tdata;
            phase_next            = PH_LSB;
          end
          PH_LSB: begin
            low_byte_hold_next    = s_axis_tdata;
            running_checksum_next = running_checksum ^ s_axis_tdata;
            phase_next            = PH_CHECK;
          end
          PH_PAYLOAD: begin
            running_checksum_next = running_checksum ^ s_axis_tdata;
            if (!pair_mode) begin
              res_valid          = 1'b1;
              res.kind           = KIND_ELEMENT;
              res.value          = {8'd0, s_axis_tdata};
              res.element_number = payload_bytes_taken[7:0];
            end else if (!payload_bytes_taken[0]) begin
              high_byte_hold_next = s_axis_tdata;
            end else begin
              res_valid          = 1'b1;
              res.kind           = KIND_ELEMENT;
              res.value          = {high_byte_hold, s_axis_tdata};
              res.element_number = payload_bytes_taken[8:1];
            end
            payload_bytes_taken_next = taken_inc;
            if (taken_inc >= payload_total) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            if (s_axis_tdata != running_checksum) begin
              checksum_error_count_next = checksum_error_count + 32'd1;
              res.kind = KIND_CSUM_ERR;
            end else if (payload_total == 9'd0 && !is_payload_cmd) begin
              res.kind  = KIND_REPORT;
              res.value = {high_byte_hold, low_byte_hold};
            end else begin
              res.kind = KIND_FRAME_OK;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end

    res.timeouts_seen        = timeout_count_next;
    res.checksum_errors_seen = checksum_error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      frame_command        <= 8'd0;
      frame_object         <= 8'd0;
      frame_index          <= 8'd0;
      high_byte_hold       <= 8'd0;
      low_byte_hold        <= 8'd0;
      running_checksum     <= 8'd0;
      payload_bytes_taken  <= 9'd0;
      payload_total        <= 9'd0;
      pair_mode            <= 1'b0;
      gap_ticks            <= 16'd0;
      timeout_count        <= 32'd0;
      checksum_error_count <= 32'd0;
    end else begin
      phase                <= phase_next;
      frame_command        <= frame_command_next;
      frame_object         <= frame_object_next;
      frame_index          <= frame_index_next;
      high_byte_hold       <= high_byte_hold_next;
      low_byte_hold        <= low_byte_hold_next;
      running_checksum     <= running_checksum_next;
      payload_bytes_taken  <= payload_bytes_taken_next;
      payload_total        <= payload_total_next;
      pair_mode            <= pair_mode_next;
      gap_ticks            <= gap_ticks_next;
      timeout_count        <= timeout_count_next;
      checksum_error_count <= checksum_error_count_next;
    end
  end

  // Output register plus skid register; results leave in arrival order.
  assign push = accept & res_valid;
  assign pop  = out_valid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid) begin
        out_valid <= push;
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= push;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (push && (skid_valid || (out_valid && !pop))) begin
      skid_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_data.kind;
  assign m_axis_tdata  = {out_data.checksum_errors_seen, out_data.timeouts_seen,
                          out_data.element_number, out_data.value,
                          out_data.index_or_length, out_data.object_id,
                          out_data.command};

endmodule

`default_nettype wire
